// ===== sv/assert_macros.svh =====
// Assertion helpers for the life grid engine.
// CHECK_RUN is muted while reset is high; CHECK_ALWAYS also checks in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tlge_pkg.sv =====
// ----------------------------------------------------------------------------
// tlge_pkg
// Types and constants of the toroidal life grid engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tlge_pkg;

  localparam int MAX_SIZE_DEF = 256;
  localparam int SIZE_W       = 9;
  localparam int COORD_W      = 8;
  localparam int CNT_W        = 17;
  localparam int GEN_W        = 32;
  localparam int MIN_SIZE     = 3;
  localparam int CFG_RESET    = 256;

  // B3/S23 rule
  localparam int BIRTH_N   = 3;
  localparam int SURVIVE_N = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               write_value;
  } req_t;

  typedef struct packed {
    logic               read_value;
    logic [CNT_W-1:0]   living_count;
    logic [GEN_W-1:0]   generation_count;
    logic               coord_error;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/toroidal_life_grid_engine_unit.sv =====
// Cell read or write: result strobe registered in S_CELL, the state after the start
//   transfer; a coordinate out of range or an unused code strobes in the next cycle.
// Advance: strobe after S_LOAD0 and S_LOAD1, then one row per cycle through
//   the board memory read port, then one row per cycle copying back, then S_DRAIN.
// One item at a time: busy stays high until the strobe. Results cannot be held off.
// Reset (sync): counters cleared, then every board row cleared in S_CLEAR with busy high.
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_unit
// Life (B3/S23) on a wrapped square board held row-wide in block memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module toroidal_life_grid_engine_unit #(
  parameter int MAX_SIZE = tlge_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  tlge_pkg::req_t              req,
  output logic                        done,
  output tlge_pkg::rsp_t              rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tlge_pkg::SIZE_W-1:0] cfg_data
);
  import tlge_pkg::*;

  // Row address width, and a width that holds any row index or size plus carry
  localparam int AW      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int RW      = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  // Live count pipeline: 8-bit chunks, groups of eight chunks
  localparam int N_GRP   = (MAX_SIZE + 63) / 64;
  localparam int N_CHUNK = N_GRP * 8;
  localparam int PAD_W   = N_GRP * 64;
  localparam int SUM_W   = $clog2(MAX_SIZE + 1);
  localparam int ACC_W   = CNT_W + 1;

  localparam logic [AW-1:0]     LAST_ROW   = AW'(MAX_SIZE - 1);
  localparam logic [SIZE_W-1:0] RESET_SIZE =
    SIZE_W'((MAX_SIZE < CFG_RESET) ? MAX_SIZE : CFG_RESET);

  // Sequencer
  //   S_CLEAR : zero one board row per cycle after reset
  //   S_CELL  : board row read back; finish the read or the read-modify-write
  //   S_LOAD0 : capture row n-1 (row above row 0)
  //   S_LOAD1 : capture row 0
  //   S_ROW   : one new row per cycle into the next-board memory
  //   S_COPY  : next-board rows copied back, one per cycle
  //   S_DRAIN : wait for the live count pipeline, then post the result
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CELL  = 8'b0000_0100,
    S_LOAD0 = 8'b0000_1000,
    S_LOAD1 = 8'b0001_0000,
    S_ROW   = 8'b0010_0000,
    S_COPY  = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_t;

  state_t state;

  // Control registers
  logic [AW-1:0]     r_idx;     // clear, compute and copy row pointer
  logic [SIZE_W-1:0] size_q;    // active size, already clamped
  logic [GEN_W-1:0]  gen_q;
  logic [CNT_W-1:0]  live_q;
  logic [CNT_W-1:0]  acc_q;     // live count of the generation being built
  logic [2:0]        cnt_v;     // count pipeline stage valids

  // Payload registers
  logic [AW-1:0]       row_q;
  logic [AW-1:0]       col_q;
  logic                wv_q;
  logic                op_write;
  logic [MAX_SIZE-1:0] w_up;    // row above the one being computed
  logic [MAX_SIZE-1:0] w_mid;   // row being computed; row below is brd_data
  logic [MAX_SIZE-1:0] cnt_row;
  logic [3:0]          cnt_chunk [N_CHUNK];
  logic [6:0]          cnt_grp   [N_GRP];

  // Memories: one row of cells per word
  logic [MAX_SIZE-1:0] board_mem [MAX_SIZE];
  logic [MAX_SIZE-1:0] next_mem  [MAX_SIZE];
  logic [MAX_SIZE-1:0] brd_data;
  logic [MAX_SIZE-1:0] nrd_data;

  logic                bwr_en, brd_en, nwr_en, nrd_en;
  logic [AW-1:0]       bwr_addr, brd_addr, nwr_addr, nrd_addr;
  logic [MAX_SIZE-1:0] bwr_data, nwr_data;

  // Combinational
  logic                accept;
  logic                rd_err;
  logic [SIZE_W-1:0]   size_m1;
  logic [AW-1:0]       last_idx;
  logic                row_last;
  logic [RW-1:0]       nxt2;
  logic [RW-1:0]       nxt2_wrap;
  logic [SIZE_W-1:0]   size_clamped;
  logic [MAX_SIZE-1:0] win [3];
  logic [MAX_SIZE-1:0] lsh [3];
  logic [MAX_SIZE-1:0] rsh [3];
  logic [MAX_SIZE-1:0] new_row;
  logic [MAX_SIZE-1:0] col_act;
  logic [3:0]          cnt_chunk_next [N_CHUNK];
  logic [6:0]          cnt_grp_next   [N_GRP];
  logic [CNT_W-1:0]    acc_next;
  logic                done_next;
  rsp_t                rsp_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign rd_err   = (SIZE_W'(req.row) >= size_q) || (SIZE_W'(req.column) >= size_q);
  assign size_m1  = size_q - 1'b1;
  assign last_idx = AW'(size_m1);
  assign row_last = (RW'(r_idx) == RW'(size_m1));

  // Row two below the current one, wrapped; r + 2 < 2n so one subtract does
  assign nxt2      = RW'(r_idx) + RW'(2);
  assign nxt2_wrap = (nxt2 >= RW'(size_q)) ? nxt2 - RW'(size_q) : nxt2;

  always_comb begin
    if (cfg_data < SIZE_W'(MIN_SIZE)) begin
      size_clamped = SIZE_W'(MIN_SIZE);
    end else if (32'(cfg_data) > MAX_SIZE) begin
      size_clamped = SIZE_W'(MAX_SIZE);
    end else begin
      size_clamped = cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Next-generation row. Left/right neighbours wrap at the active size;
  // columns beyond it keep their old value and are not counted.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [3:0] nb;
    logic       alive;
    win[0] = w_up;
    win[1] = w_mid;
    win[2] = brd_data;
    for (int k = 0; k < 3; k++) begin
      lsh[k] = {win[k][MAX_SIZE-2:0], win[k][last_idx]};
      rsh[k] = {1'b0, win[k][MAX_SIZE-1:1]};
      rsh[k][last_idx] = win[k][0];
    end
    for (int c = 0; c < MAX_SIZE; c++) begin
      col_act[c] = (c < 32'(size_q));
      nb = 4'(lsh[0][c]) + 4'(win[0][c]) + 4'(rsh[0][c])
         + 4'(lsh[1][c])                 + 4'(rsh[1][c])
         + 4'(lsh[2][c]) + 4'(win[2][c]) + 4'(rsh[2][c]);
      alive = (nb == 4'(BIRTH_N)) || ((nb == 4'(SURVIVE_N)) && win[1][c]);
      new_row[c] = col_act[c] ? alive : win[1][c];
    end
  end

  // --------------------------------------------------------------------------
  // Live count: row register, 8-bit chunk counts, group sums, accumulate.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [PAD_W-1:0] pad;
    logic [SUM_W-1:0] tot;
    logic [ACC_W-1:0] wide;
    pad = PAD_W'(cnt_row);
    for (int k = 0; k < N_CHUNK; k++) begin
      cnt_chunk_next[k] = '0;
      for (int b = 0; b < 8; b++) begin
        cnt_chunk_next[k] = cnt_chunk_next[k] + 4'(pad[k*8+b]);
      end
    end
    for (int g = 0; g < N_GRP; g++) begin
      cnt_grp_next[g] = '0;
      for (int j = 0; j < 8; j++) begin
        cnt_grp_next[g] = cnt_grp_next[g] + 7'(cnt_chunk[g*8+j]);
      end
    end
    tot = '0;
    for (int g = 0; g < N_GRP; g++) begin
      tot = tot + SUM_W'(cnt_grp[g]);
    end
    // saturating; the count only grows so this matches clamping at the end
    wide = {1'b0, acc_q} + ACC_W'(tot);
    acc_next = (wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : wide[CNT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Memory port steering
  // --------------------------------------------------------------------------
  always_comb begin
    bwr_en   = 1'b0;
    bwr_addr = r_idx;
    bwr_data = '0;
    brd_en   = 1'b0;
    brd_addr = AW'(req.row);
    nwr_en   = 1'b0;
    nwr_addr = r_idx;
    nwr_data = new_row;
    nrd_en   = 1'b0;
    nrd_addr = '0;
    case (state)
      S_CLEAR: begin
        bwr_en = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_WRITE, REQ_READ: begin
              brd_en = !rd_err;
            end
            REQ_ADVANCE: begin
              brd_en   = 1'b1;
              brd_addr = last_idx;
            end
            default: ;
          endcase
        end
      end
      S_CELL: begin
        // read-modify-write of the addressed row
        bwr_en          = op_write;
        bwr_addr        = row_q;
        bwr_data        = brd_data;
        bwr_data[col_q] = wv_q;
      end
      S_LOAD0: begin
        brd_en   = 1'b1;
        brd_addr = '0;
      end
      S_LOAD1: begin
        brd_en   = 1'b1;
        brd_addr = AW'(1);
      end
      S_ROW: begin
        nwr_en   = 1'b1;
        brd_en   = 1'b1;
        brd_addr = AW'(nxt2_wrap);
        nrd_en   = row_last;
      end
      S_COPY: begin
        bwr_en   = 1'b1;
        bwr_data = nrd_data;
        nrd_en   = !row_last;
        nrd_addr = r_idx + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bwr_en) begin
      board_mem[bwr_addr] <= bwr_data;
    end
    if (brd_en) begin
      brd_data <= board_mem[brd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      next_mem[nwr_addr] <= nwr_data;
    end
    if (nrd_en) begin
      nrd_data <= next_mem[nrd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    done_next                 = 1'b0;
    rsp_next.read_value       = 1'b0;
    rsp_next.living_count     = live_q;
    rsp_next.generation_count = gen_q;
    rsp_next.coord_error      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_WRITE, REQ_READ: begin
              done_next            = rd_err;
              rsp_next.coord_error = rd_err;
            end
            REQ_ADVANCE: ;
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_CELL: begin
        done_next           = 1'b1;
        rsp_next.read_value = !op_write && brd_data[col_q];
      end
      S_DRAIN: begin
        if (cnt_v == '0) begin
          done_next                 = 1'b1;
          rsp_next.living_count     = acc_q;
          rsp_next.generation_count = gen_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      r_idx  <= '0;
      size_q <= RESET_SIZE;
      gen_q  <= '0;
      live_q <= '0;
      acc_q  <= '0;
      cnt_v  <= '0;
      done   <= 1'b0;
    end else begin
      done  <= done_next;
      cnt_v <= {cnt_v[1:0], (state == S_ROW)};
      if (cfg_valid && cfg_ready) begin
        size_q <= size_clamped;
      end
      if (cnt_v[2]) begin
        acc_q <= acc_next;
      end
      case (state)
        S_CLEAR: begin
          if (r_idx == LAST_ROW) begin
            r_idx <= '0;
            state <= S_IDLE;
          end else begin
            r_idx <= r_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_ADVANCE: begin
                acc_q <= '0;
                r_idx <= '0;
                state <= S_LOAD0;
              end
              REQ_WRITE, REQ_READ: begin
                if (!rd_err) begin
                  state <= S_CELL;
                end
              end
              default: ;
            endcase
          end
        end
        S_CELL: begin
          state <= S_IDLE;
        end
        S_LOAD0: begin
          state <= S_LOAD1;
        end
        S_LOAD1: begin
          state <= S_ROW;
        end
        S_ROW: begin
          if (row_last) begin
            r_idx <= '0;
            state <= S_COPY;
          end else begin
            r_idx <= r_idx + 1'b1;
          end
        end
        S_COPY: begin
          if (row_last) begin
            r_idx <= '0;
            state <= S_DRAIN;
          end else begin
            r_idx <= r_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cnt_v == '0) begin
            live_q <= acc_q;
            gen_q  <= gen_q + 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    rsp       <= rsp_next;
    cnt_row   <= new_row & col_act;
    cnt_chunk <= cnt_chunk_next;
    cnt_grp   <= cnt_grp_next;
    if (accept) begin
      row_q    <= AW'(req.row);
      col_q    <= AW'(req.column);
      wv_q     <= req.write_value;
      op_write <= (req.req_type == REQ_WRITE);
    end
    case (state)
      S_LOAD0: begin
        w_up <= brd_data;
      end
      S_LOAD1: begin
        w_mid <= brd_data;
      end
      S_ROW: begin
        w_up  <= w_mid;
        w_mid <= brd_data;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `CHECK_ALWAYS(a_reset_clears, $fell(rst) |-> (state == S_CLEAR), "no clear pass after reset")
  `CHECK_RUN(a_row_in_range, (state == S_ROW || state == S_COPY) |-> (RW'(r_idx) < RW'(size_q)), "row pointer beyond active size")
  `CHECK_RUN(a_gen_with_result, (gen_q != $past(gen_q)) |-> done, "generation moved without a result")
  `CHECK_RUN(a_count_drained, done |-> (cnt_v == '0), "result posted with live count in flight")

endmodule

`default_nettype wire
